// File: design/ahmlp_pkg.sv
// Package for the hex message line parser: sizes, column positions, codes,
// the result word type and the hex digit decoder.
// Depends on nothing; used by ahmlp_line_core and the top level.
`timescale 1ns / 1ps

package ahmlp_pkg;

   localparam int LINE_CAPACITY = 512;
   localparam int MAX_PAYLOAD   = 223;
   localparam int COL_W         = $clog2(LINE_CAPACITY + 1);

   localparam logic [7:0] STARTER_CHAR = 8'h41;
   localparam logic [7:0] LINE_FEED    = 8'h0A;
   localparam logic [7:0] NUL_CHAR     = 8'h00;

   localparam logic [COL_W-1:0] STARTER_COL = COL_W'(0);
   localparam logic [COL_W-1:0] SOURCE_COL  = COL_W'(12);
   localparam logic [COL_W-1:0] SOURCE_END  = COL_W'(13);
   localparam logic [COL_W-1:0] DEST_COL    = COL_W'(14);
   localparam logic [COL_W-1:0] DEST_END    = COL_W'(15);
   localparam logic [COL_W-1:0] PRIO_COL    = COL_W'(16);
   localparam logic [COL_W-1:0] PGN_COL     = COL_W'(18);
   localparam logic [COL_W-1:0] PGN_END     = COL_W'(22);
   localparam logic [COL_W-1:0] PAYLOAD_COL = COL_W'(24);
   localparam logic [COL_W-1:0] CAPACITY    = COL_W'(LINE_CAPACITY);
   localparam logic [7:0]       PAYLOAD_MAX = 8'(MAX_PAYLOAD);

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_STARTER = 2'd1,
      STATUS_SHORT       = 2'd2
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [7:0]  source_addr;
      logic [7:0]  dest_addr;
      logic [3:0]  priority_res;
      logic [19:0] pgn;
      status_type  status;
      logic [7:0]  byte_count;
   } result_type;

   // Bit 4 set means the character is not a hex digit.
   function automatic logic [4:0] hex_value(input logic [7:0] ch);
      logic [4:0] v;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         v = {1'b0, 4'(ch - 8'h30)};
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         v = {1'b0, 4'(ch - 8'h37)};
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         v = {1'b0, 4'(ch - 8'h57)};
      end else begin
         v = 5'h10;
      end
      return v;
   endfunction

endpackage

// File: design/ahmlp_line_core.sv
// Line state of the parser: column counter, header field accumulators and
// payload pairing, with the result word each character produces.
// Depends on ahmlp_pkg.
`timescale 1ns / 1ps

module ahmlp_line_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            ch,
   output logic                  res_valid,
   output ahmlp_pkg::result_type res
);
   import ahmlp_pkg::*;

   logic [COL_W-1:0] column_ff, column_in;
   logic             starter_ok_ff, starter_ok_in;
   logic [7:0]       source_acc_ff, source_acc_in;
   logic [7:0]       dest_acc_ff, dest_acc_in;
   logic [3:0]       prio_acc_ff, prio_acc_in;
   logic [19:0]      pgn_acc_ff, pgn_acc_in;
   logic             stopped_ff, stopped_in;
   logic [3:0]       pair_high_ff, pair_high_in;
   logic [7:0]       count_ff, count_in;
   logic             nul_seen_ff, nul_seen_in;

   logic [4:0] hv;
   logic       is_hex;
   logic [3:0] d;
   logic       eff_stopped;

   assign hv     = hex_value(ch);
   assign is_hex = !hv[4];
   assign d      = hv[3:0];

   always_comb begin
      column_in     = column_ff;
      starter_ok_in = starter_ok_ff;
      source_acc_in = source_acc_ff;
      dest_acc_in   = dest_acc_ff;
      prio_acc_in   = prio_acc_ff;
      pgn_acc_in    = pgn_acc_ff;
      stopped_in    = stopped_ff;
      pair_high_in  = pair_high_ff;
      count_in      = count_ff;
      nul_seen_in   = nul_seen_ff;
      res_valid     = 1'b0;
      res           = '0;
      eff_stopped   = stopped_ff;

      if (ch == LINE_FEED) begin
         if (column_ff != '0) begin
            res_valid = 1'b1;
            res.kind  = KIND_SUMMARY;
            if (!starter_ok_ff) begin
               res.status = STATUS_BAD_STARTER;
            end else if (column_ff < PAYLOAD_COL) begin
               res.status = STATUS_SHORT;
            end else begin
               res.status       = STATUS_OK;
               res.source_addr  = source_acc_ff;
               res.dest_addr    = dest_acc_ff;
               res.priority_res = prio_acc_ff;
               res.pgn          = pgn_acc_ff;
               res.byte_count   = count_ff;
            end
         end
         column_in     = '0;
         starter_ok_in = 1'b0;
         source_acc_in = '0;
         dest_acc_in   = '0;
         prio_acc_in   = '0;
         pgn_acc_in    = '0;
         stopped_in    = 1'b0;
         pair_high_in  = '0;
         count_in      = '0;
         nul_seen_in   = 1'b0;
      end else if (nul_seen_ff || column_ff >= CAPACITY) begin
         nul_seen_in = nul_seen_ff;
      end else if (ch == NUL_CHAR) begin
         nul_seen_in = 1'b1;
      end else begin
         column_in = column_ff + COL_W'(1);
         if (column_ff == STARTER_COL || column_ff == SOURCE_COL || column_ff == DEST_COL
             || column_ff == PRIO_COL || column_ff == PGN_COL) begin
            eff_stopped = 1'b0;
         end
         if (column_ff == STARTER_COL) begin
            starter_ok_in = (ch == STARTER_CHAR);
         end else if (column_ff == SOURCE_COL || column_ff == SOURCE_END) begin
            if (!eff_stopped && is_hex) begin
               source_acc_in = (column_ff == SOURCE_COL) ? {4'h0, d} : {source_acc_ff[3:0], d};
            end else if (column_ff == SOURCE_COL) begin
               source_acc_in = '0;
            end
            stopped_in = eff_stopped || !is_hex;
         end else if (column_ff == DEST_COL || column_ff == DEST_END) begin
            if (!eff_stopped && is_hex) begin
               dest_acc_in = (column_ff == DEST_COL) ? {4'h0, d} : {dest_acc_ff[3:0], d};
            end else if (column_ff == DEST_COL) begin
               dest_acc_in = '0;
            end
            stopped_in = eff_stopped || !is_hex;
         end else if (column_ff == PRIO_COL) begin
            prio_acc_in = is_hex ? d : 4'h0;
            stopped_in  = !is_hex;
         end else if (column_ff >= PGN_COL && column_ff <= PGN_END) begin
            if (!eff_stopped && is_hex) begin
               pgn_acc_in = (column_ff == PGN_COL) ? {16'h0, d} : {pgn_acc_ff[15:0], d};
            end else if (column_ff == PGN_COL) begin
               pgn_acc_in = '0;
            end
            stopped_in = eff_stopped || !is_hex;
         end else if (column_ff >= PAYLOAD_COL) begin
            if (!column_ff[0]) begin
               stopped_in   = !is_hex;
               pair_high_in = is_hex ? d : 4'h0;
            end else if (starter_ok_ff && count_ff < PAYLOAD_MAX) begin
               count_in      = count_ff + 8'd1;
               res_valid     = 1'b1;
               res.kind      = KIND_PAYLOAD;
               res.status    = STATUS_OK;
               if (stopped_ff) begin
                  res.data_byte = 8'h00;
               end else if (is_hex) begin
                  res.data_byte = {pair_high_ff, d};
               end else begin
                  res.data_byte = {4'h0, pair_high_ff};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         starter_ok_ff <= 1'b0;
         source_acc_ff <= '0;
         dest_acc_ff   <= '0;
         prio_acc_ff   <= '0;
         pgn_acc_ff    <= '0;
         stopped_ff    <= 1'b0;
         pair_high_ff  <= '0;
         count_ff      <= '0;
         nul_seen_ff   <= 1'b0;
      end else if (step) begin
         column_ff     <= column_in;
         starter_ok_ff <= starter_ok_in;
         source_acc_ff <= source_acc_in;
         dest_acc_ff   <= dest_acc_in;
         prio_acc_ff   <= prio_acc_in;
         pgn_acc_ff    <= pgn_acc_in;
         stopped_ff    <= stopped_in;
         pair_high_ff  <= pair_high_in;
         count_ff      <= count_in;
         nul_seen_ff   <= nul_seen_in;
      end
   end

endmodule

// File: design/ascii_hex_message_line_parser.sv
// Top level of the hex message line parser: input word register, line core and result
// register with valid/ready on both sides; depends on ahmlp_pkg and ahmlp_line_core.
// A character is taken into the input word register; when it advances, its result word, if any, is registered.
// Throughput: one character per cycle while rsp_ready is high.
// A waiting result holds the input register, so req_ready falls once that register is full.
// Synchronous active-high reset clears the line state and both valid flags.
`timescale 1ns / 1ps

module ascii_hex_message_line_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_character,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_kind,
   output logic [7:0]            rsp_data_byte,
   output logic [7:0]            rsp_source_addr,
   output logic [7:0]            rsp_dest_addr,
   output logic [3:0]            rsp_priority_res,
   output logic [19:0]           rsp_pgn,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_byte_count
);
   import ahmlp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       out_valid_ff, out_valid_in;
   result_type result_ff;

   logic       advance;
   logic       core_valid;
   result_type core_res;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   ahmlp_line_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .ch        (in_char_ff),
      .res_valid (core_valid),
      .res       (core_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = core_valid;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_character;
      end
      if (advance && core_valid) begin
         result_ff <= core_res;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = result_ff.kind;
   assign rsp_data_byte    = result_ff.data_byte;
   assign rsp_source_addr  = result_ff.source_addr;
   assign rsp_dest_addr    = result_ff.dest_addr;
   assign rsp_priority_res = result_ff.priority_res;
   assign rsp_pgn          = result_ff.pgn;
   assign rsp_status       = result_ff.status;
   assign rsp_byte_count   = result_ff.byte_count;

endmodule
